[rtl/core/sdtq_pkg.sv]
// Shared types and constants for the sorted deadline timer queue.
package sdtq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned MaxPerTick = 16;

  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_QUIET   = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One stored alarm.
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  tag;
    logic [15:0] delay;
  } entry_t;

endpackage

[rtl/core/sdtq_ram.sv]
// Entry memory of the timer queue: one write port, one registered read port.
module sdtq_ram
  import sdtq_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  localparam int unsigned AddrW = $clog2(QueueDepth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [QueueDepth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/sorted_deadline_timer_queue.sv]
// Top level of the sorted deadline timer queue.
// Alarms live in a circular buffer in one memory with a registered read, kept
// sorted by deadline, the earliest at the head. An insert request searches
// from the tail, moving each later or equal entry up one place. A zero delay,
// a full table or an empty table is answered without a search. A tick request
// reads the head entry once per expiry. One request is handled at a time; a
// waiting result blocks the input, and the next request is taken in the cycle
// that the result is accepted.
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] delay_seconds_i,
  input  logic [7:0]  alarm_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  expired_tag_o,
  output logic [15:0] expired_delay_o,
  output logic        last_result_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW    = $clog2(MaxPerTick + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;  // read issued for an insert
  localparam logic [2:0] S_SCMP  = 3'd2;  // compare read entry
  localparam logic [2:0] S_TRD   = 3'd3;  // head read issued for a tick
  localparam logic [2:0] S_TCMP  = 3'd4;  // compare head entry
  localparam logic [2:0] S_EMIT  = 3'd5;  // wait for the result register

  logic [2:0]      state_q, state_d;
  logic [31:0]     time_q, time_d;
  logic [CntW-1:0] count_q, count_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0] idx_q, idx_d;     // offset of slot being examined
  logic [NW-1:0]   n_q, n_d;
  entry_t          new_q, new_d;
  logic            emit_last_q, emit_last_d;

  logic            ov_q, ov_d;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      tag_q, tag_d;
  logic [15:0]     dly_q, dly_d;
  logic            last_q, last_d;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic [32:0]     sum;
  logic            out_free;

  sdtq_ram #(.QueueDepth(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Physical slot of a logical offset from the head, wrapping at depth.
  function automatic logic [AddrW-1:0] slot(input logic [AddrW-1:0] head,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = {1'b0, CntW'(head)} + {1'b0, off};
    if (s >= (CntW+1)'(QUEUE_DEPTH)) begin
      s = s - (CntW+1)'(QUEUE_DEPTH);
    end
    return s[AddrW-1:0];
  endfunction

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign sum        = {1'b0, time_q} + {17'd0, delay_seconds_i};

  // Sequencer: insert search, tick expiry and result hand-off.
  always_comb begin
    state_d = state_q;
    time_d = time_q;
    count_d = count_q;
    head_d = head_q;
    idx_d = idx_q;
    n_d = n_q;
    new_d = new_q;
    emit_last_d = emit_last_q;
    ov_d = ov_q && out_stall_i;
    kind_d = kind_q;
    tag_d = tag_q;
    dly_d = dly_q;
    last_d = last_q;
    we = 1'b0;
    waddr = '0;
    wdata = new_q;
    raddr = slot(head_q, idx_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && out_free) begin
          if (operation_i == OP_INSERT) begin
            tag_d = alarm_tag_i;
            last_d = 1'b1;
            if (delay_seconds_i == '0) begin
              ov_d = 1'b1; kind_d = KIND_EXPIRED; dly_d = '0;
            end else if (count_q >= Full) begin
              ov_d = 1'b1; kind_d = KIND_FULL; dly_d = delay_seconds_i;
            end else begin
              new_d.deadline = sum[32] ? '1 : sum[31:0];
              new_d.tag = alarm_tag_i;
              new_d.delay = delay_seconds_i;
              dly_d = delay_seconds_i;
              if (count_q == '0) begin
                we = 1'b1;
                waddr = head_q;
                wdata = new_d;
                count_d = count_q + 1'b1;
                ov_d = 1'b1; kind_d = KIND_ACCEPT;
              end else begin
                idx_d = count_q - 1'b1;
                state_d = S_SRCH;
              end
            end
          end else begin
            if (time_q != '1) time_d = time_q + 1'b1;
            n_d = '0;
            idx_d = '0;
            state_d = S_TRD;
          end
        end
      end
      S_SRCH: state_d = S_SCMP;
      S_SCMP: begin
        we = 1'b1;
        if (rdata.deadline >= new_q.deadline) begin
          // Later or equal deadline: move it up one place.
          waddr = slot(head_q, idx_q + 1'b1);
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = S_EMIT;
            emit_last_d = 1'b1;
          end else begin
            idx_d = idx_q - 1'b1;
            state_d = S_SRCH;
          end
        end else begin
          waddr = slot(head_q, idx_q + 1'b1);
          wdata = new_q;
          state_d = S_EMIT;
          emit_last_d = 1'b0;
        end
      end
      S_EMIT: begin
        // Insert done: place at head if scan ran out, then report.
        if (emit_last_q) begin
          we = 1'b1;
          waddr = head_q;
          wdata = new_q;
          emit_last_d = 1'b0;
        end else if (out_free) begin
          count_d = count_q + 1'b1;
          ov_d = 1'b1; kind_d = KIND_ACCEPT; tag_d = new_q.tag;
          dly_d = new_q.delay; last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        if (count_q == '0 || n_q == NW'(MaxPerTick)) begin
          if (out_free) begin
            ov_d = 1'b1;
            if (n_q == '0) begin
              kind_d = KIND_QUIET; tag_d = '0; dly_d = '0;
            end else begin
              kind_d = KIND_EXPIRED; tag_d = new_q.tag; dly_d = new_q.delay;
            end
            last_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_TCMP;
        end
      end
      S_TCMP: begin
        if (rdata.deadline <= time_q) begin
          if (n_q != '0 && !out_free) begin
            state_d = S_TCMP;
          end else begin
            if (n_q != '0) begin
              ov_d = 1'b1; kind_d = KIND_EXPIRED; tag_d = new_q.tag;
              dly_d = new_q.delay; last_d = 1'b0;
            end
            new_d = rdata;
            n_d = n_q + 1'b1;
            head_d = slot(head_q, CntW'(1));
            count_d = count_q - 1'b1;
            state_d = S_TRD;
          end
        end else if (out_free) begin
          ov_d = 1'b1;
          if (n_q == '0) begin
            kind_d = KIND_QUIET; tag_d = '0; dly_d = '0;
          end else begin
            kind_d = KIND_EXPIRED; tag_d = new_q.tag; dly_d = new_q.delay;
          end
          last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_d == S_TRD || state_d == S_TCMP) raddr = head_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      time_q <= '0;
      count_q <= '0;
      head_q <= '0;
      ov_q <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      time_q <= time_d;
      count_q <= count_d;
      head_q <= head_d;
      ov_q <= ov_d;
      emit_last_q <= emit_last_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    n_q <= n_d;
    new_q <= new_d;
    kind_q <= kind_d;
    tag_q <= tag_d;
    dly_q <= dly_d;
    last_q <= last_d;
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = kind_q;
  assign expired_tag_o   = tag_q;
  assign expired_delay_o = dly_q;
  assign last_result_o   = last_q;

  // The table never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Full)
    else $error("entry count above depth");

  // A pending result holds while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(kind_q) && $stable(tag_q))
    else $error("stalled result changed");

  // Time never goes backwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q >= $past(time_q))
    else $error("time decreased");

endmodule

[tb/sv/sorted_deadline_timer_queue_tb.sv]
// Testbench for the sorted deadline timer queue: random and directed requests.
`timescale 1ns / 100ps

module sorted_deadline_timer_queue_tb;
  import sdtq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [15:0] delay;
    logic        last;
  } alarm_result_t;

  // Scoreboard: mirrors the alarm table and keeps the expected results.
  class alarm_scoreboard;
    logic [31:0]   clock_now;
    entry_t        alarms[$];
    alarm_result_t pending[$];
    int unsigned   mismatches;

    function void clear();
      clock_now = '0;
      alarms.delete();
      pending.delete();
      mismatches = 0;
    endfunction

    function void note_request(logic op, logic [15:0] dly, logic [7:0] tg);
      logic [32:0] sum;
      entry_t      e;
      int          pos;
      int          n;
      n = 0;
      if (op == OP_INSERT) begin
        if (dly == 16'd0) begin
          pending.push_back('{KIND_EXPIRED, tg, 16'd0, 1'b1});
        end else if (alarms.size() >= Depth) begin
          pending.push_back('{KIND_FULL, tg, dly, 1'b1});
        end else begin
          sum = {1'b0, clock_now} + {17'd0, dly};
          e.deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          e.tag = tg;
          e.delay = dly;
          pos = 0;
          while (pos < alarms.size() && alarms[pos].deadline < e.deadline) pos++;
          alarms.insert(pos, e);
          pending.push_back('{KIND_ACCEPT, tg, dly, 1'b1});
        end
      end else begin
        if (clock_now != 32'hFFFF_FFFF) clock_now++;
        while (n < MaxPerTick && alarms.size() > 0 && alarms[0].deadline <= clock_now) begin
          pending.push_back('{KIND_EXPIRED, alarms[0].tag, alarms[0].delay, 1'b0});
          void'(alarms.pop_front());
          n++;
        end
        if (n == 0) pending.push_back('{KIND_QUIET, 8'd0, 16'd0, 1'b1});
        else pending[pending.size()-1].last = 1'b1;
      end
    endfunction

    function void check_result(alarm_result_t got);
      alarm_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [15:0] delay_seconds_i;
  logic [7:0]  alarm_tag_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  expired_tag_o;
  logic [15:0] expired_delay_o;
  logic        last_result_o;

  alarm_scoreboard board;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  longint unsigned cycles;
  int unsigned     results_seen;

  sorted_deadline_timer_queue #(.QUEUE_DEPTH(Depth)) u_top (.*);

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result checking and receiver stalls.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result('{result_kind_o, expired_tag_o, expired_delay_o, last_result_o});
      results_seen++;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sends one request, with random idle cycles before it.
  task automatic send_request(logic op, logic [15:0] dly, logic [7:0] tg);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    delay_seconds_i = dly;
    alarm_tag_i = tg;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(op, dly, tg);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    operation_i = 1'($urandom_range(1));
    delay_seconds_i = 16'($urandom);
    alarm_tag_i = 8'($urandom);
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  // Random request: inserts mostly small delays so that ticks expire them.
  task automatic send_random();
    logic [15:0] dly;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      send_request(OP_TICK, 16'($urandom), 8'($urandom));
    end else begin
      if (r < 80) dly = 16'($urandom_range(1, 12));
      else if (r < 88) dly = 16'd0;
      else if (r < 94) dly = 16'($urandom);
      else dly = 16'hFFFF - 16'($urandom_range(3));
      send_request(OP_INSERT, dly, 8'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    cycles = 0;
    results_seen = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_INSERT;
    delay_seconds_i = '0;
    alarm_tag_i = '0;
    out_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: quiet tick, zero delay, equal deadlines, fill past full, mass expiry.
    send_request(OP_TICK, 16'hFFFF, 8'hFF);
    send_request(OP_INSERT, 16'd0, 8'hFF);
    send_request(OP_INSERT, 16'd2, 8'h01);
    send_request(OP_INSERT, 16'd2, 8'h02);
    send_request(OP_INSERT, 16'd1, 8'h03);
    for (int i = 0; i < 14; i++) send_request(OP_INSERT, 16'd3, 8'(16 + i));
    send_request(OP_INSERT, 16'hFFFF, 8'hAA);
    send_request(OP_INSERT, 16'd0, 8'h55);
    for (int i = 0; i < 4; i++) send_request(OP_TICK, 16'd0, 8'd0);
    wait_drained();

    // Random phases with different idle and stall mixes.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 52) : 0;
      stall_pct = (phase == 2) ? 52 : ((phase == 3) ? 26 : 0);
      for (int i = 0; i < 95; i++) begin
        send_random();
        if (i == 50) wait_drained();
      end
    end

    wait_drained();
    repeat (2 * Depth + 10) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
